// File: design/kuf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package kuf_pkg;

    localparam int MAX_NODES_DEF = 256;
    localparam int NODE_W        = 8;
    localparam int CFG_W         = 9;
    localparam int CFG_IDX_W     = 2;

    localparam logic [CFG_W-1:0] NODE_COUNT_RST    = 9'd256;
    localparam logic [CFG_W-1:0] CLUSTER_COUNT_RST = 9'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NODE_COUNT    = 2'd0,
        CFG_CLUSTER_COUNT = 2'd1
    } cfg_reg_e;

    typedef struct packed {
        logic              action;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } item_t;

    typedef struct packed {
        logic              accepted;
        logic [NODE_W-1:0] tree_edge_index;
        logic              cut_edge;
        logic [NODE_W-1:0] merged_root;
        logic              tree_complete;
        logic              bad_node;
    } result_t;

    typedef enum logic [3:0] {
        ST_BOOT_CLR = 4'd0,
        ST_IDLE     = 4'd1,
        ST_DISPATCH = 4'd2,
        ST_SEED_A   = 4'd3,
        ST_WALK_A   = 4'd4,
        ST_SEED_B   = 4'd5,
        ST_WALK_B   = 4'd6,
        ST_ROOTS    = 4'd7,
        ST_UNION    = 4'd8,
        ST_SAME_OUT = 4'd9,
        ST_BAD_OUT  = 4'd10,
        ST_INIT_CLR = 4'd11,
        ST_INIT_OUT = 4'd12
    } step_e;

    typedef enum logic [2:0] {
        C_NEXT     = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_START = 3'd2,
        C_INIT     = 3'd3,
        C_BAD      = 3'd4,
        C_NOT_ROOT = 3'd5,
        C_SAME     = 3'd6,
        C_CLR_MORE = 3'd7
    } cond_e;

    typedef enum logic [1:0] {
        NODE_HOLD   = 2'd0,
        NODE_SEED_A = 2'd1,
        NODE_SEED_B = 2'd2,
        NODE_WALK   = 2'd3
    } node_op_e;

    typedef enum logic {
        SZ_RA   = 1'b0,
        SZ_NODE = 1'b1
    } size_sel_e;

    typedef enum logic [2:0] {
        OUT_NONE  = 3'd0,
        OUT_UNION = 3'd1,
        OUT_SAME  = 3'd2,
        OUT_BAD   = 3'd3,
        OUT_INIT  = 3'd4
    } emit_e;

    typedef struct packed {
        logic      idle;
        node_op_e  node_op;
        size_sel_e size_sel;
        logic      latch_ra;
        logic      latch_roots;
        logic      union_en;
        logic      clear_en;
        emit_e     emit;
        cond_e     cond;
        step_e     target;
    } uword_t;

    typedef struct packed {
        logic init;
        logic bad;
        logic root_hit;
        logic same_root;
        logic clr_last;
    } stat_t;

    localparam uword_t UW_NOP = '{
        idle:        1'b0,
        node_op:     NODE_HOLD,
        size_sel:    SZ_RA,
        latch_ra:    1'b0,
        latch_roots: 1'b0,
        union_en:    1'b0,
        clear_en:    1'b0,
        emit:        OUT_NONE,
        cond:        C_NEXT,
        target:      ST_IDLE
    };

endpackage

`default_nettype wire

// File: design/kuf_useq.sv
`timescale 1ns / 1ps
`default_nettype none

module kuf_useq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire kuf_pkg::stat_t stat,
    output kuf_pkg::uword_t     ctrl
);

    kuf_pkg::step_e upc_reg;
    kuf_pkg::step_e upc_next;
    kuf_pkg::uword_t uw;
    logic jump;

    always_comb
    begin
        uw = kuf_pkg::UW_NOP;
        case (upc_reg)
            kuf_pkg::ST_BOOT_CLR:
            begin
                uw.clear_en = 1'b1;
                uw.cond     = kuf_pkg::C_CLR_MORE;
                uw.target   = kuf_pkg::ST_BOOT_CLR;
            end
            kuf_pkg::ST_IDLE:
            begin
                uw.idle   = 1'b1;
                uw.cond   = kuf_pkg::C_NO_START;
                uw.target = kuf_pkg::ST_IDLE;
            end
            kuf_pkg::ST_DISPATCH:
            begin
                uw.cond   = kuf_pkg::C_INIT;
                uw.target = kuf_pkg::ST_INIT_CLR;
            end
            kuf_pkg::ST_SEED_A:
            begin
                uw.node_op = kuf_pkg::NODE_SEED_A;
                uw.cond    = kuf_pkg::C_BAD;
                uw.target  = kuf_pkg::ST_BAD_OUT;
            end
            kuf_pkg::ST_WALK_A:
            begin
                uw.node_op = kuf_pkg::NODE_WALK;
                uw.cond    = kuf_pkg::C_NOT_ROOT;
                uw.target  = kuf_pkg::ST_WALK_A;
            end
            kuf_pkg::ST_SEED_B:
            begin
                uw.node_op  = kuf_pkg::NODE_SEED_B;
                uw.latch_ra = 1'b1;
            end
            kuf_pkg::ST_WALK_B:
            begin
                uw.node_op  = kuf_pkg::NODE_WALK;
                uw.size_sel = kuf_pkg::SZ_RA;
                uw.cond     = kuf_pkg::C_NOT_ROOT;
                uw.target   = kuf_pkg::ST_WALK_B;
            end
            kuf_pkg::ST_ROOTS:
            begin
                uw.latch_roots = 1'b1;
                uw.size_sel    = kuf_pkg::SZ_NODE;
                uw.cond        = kuf_pkg::C_SAME;
                uw.target      = kuf_pkg::ST_SAME_OUT;
            end
            kuf_pkg::ST_UNION:
            begin
                uw.union_en = 1'b1;
                uw.emit     = kuf_pkg::OUT_UNION;
                uw.cond     = kuf_pkg::C_ALWAYS;
                uw.target   = kuf_pkg::ST_IDLE;
            end
            kuf_pkg::ST_SAME_OUT:
            begin
                uw.emit   = kuf_pkg::OUT_SAME;
                uw.cond   = kuf_pkg::C_ALWAYS;
                uw.target = kuf_pkg::ST_IDLE;
            end
            kuf_pkg::ST_BAD_OUT:
            begin
                uw.emit   = kuf_pkg::OUT_BAD;
                uw.cond   = kuf_pkg::C_ALWAYS;
                uw.target = kuf_pkg::ST_IDLE;
            end
            kuf_pkg::ST_INIT_CLR:
            begin
                uw.clear_en = 1'b1;
                uw.cond     = kuf_pkg::C_CLR_MORE;
                uw.target   = kuf_pkg::ST_INIT_CLR;
            end
            kuf_pkg::ST_INIT_OUT:
            begin
                uw.emit   = kuf_pkg::OUT_INIT;
                uw.cond   = kuf_pkg::C_ALWAYS;
                uw.target = kuf_pkg::ST_IDLE;
            end
            default:
            begin
                uw.cond   = kuf_pkg::C_ALWAYS;
                uw.target = kuf_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        case (uw.cond)
            kuf_pkg::C_NEXT:     jump = 1'b0;
            kuf_pkg::C_ALWAYS:   jump = 1'b1;
            kuf_pkg::C_NO_START: jump = !start;
            kuf_pkg::C_INIT:     jump = stat.init;
            kuf_pkg::C_BAD:      jump = stat.bad;
            kuf_pkg::C_NOT_ROOT: jump = !stat.root_hit;
            kuf_pkg::C_SAME:     jump = stat.same_root;
            kuf_pkg::C_CLR_MORE: jump = !stat.clr_last;
            default:             jump = 1'b0;
        endcase
        upc_next = jump ? uw.target : kuf_pkg::step_e'(upc_reg + 4'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= kuf_pkg::ST_BOOT_CLR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl = uw;

endmodule

`default_nettype wire

// File: design/kuf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module kuf_datapath #(
    parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire kuf_pkg::uword_t           ctrl,
    input  wire kuf_pkg::item_t            item,
    input  wire logic [kuf_pkg::CFG_W-1:0] node_count,
    input  wire logic [kuf_pkg::CFG_W-1:0] cluster_count,
    output kuf_pkg::stat_t                 stat,
    output logic                           done,
    output kuf_pkg::result_t               result
);

    localparam int AW = $clog2(MAX_NODES);
    localparam int SW = $clog2(MAX_NODES + 1);
    localparam int NW = (SW > kuf_pkg::CFG_W) ? SW : kuf_pkg::CFG_W;
    localparam int CW = NW + 1;
    localparam int XW = AW + kuf_pkg::NODE_W;

    logic [AW-1:0] parent_mem [MAX_NODES];
    logic [SW-1:0] size_mem   [MAX_NODES];

    kuf_pkg::item_t   item_reg;
    kuf_pkg::result_t result_reg;
    kuf_pkg::result_t res_next;
    logic             done_reg;
    logic             done_next;

    logic [AW-1:0] par_rdata_reg;
    logic [SW-1:0] sz_rdata_reg;
    logic [AW-1:0] node_reg;
    logic [AW-1:0] node_next;
    logic [AW-1:0] ra_reg;
    logic [AW-1:0] rb_reg;
    logic [SW-1:0] sa_reg;
    logic [AW-1:0] clr_reg;
    logic [AW-1:0] clr_next;
    logic [kuf_pkg::NODE_W-1:0] count_reg;
    logic [kuf_pkg::NODE_W-1:0] count_next;

    logic [XW-1:0] a_ext;
    logic [XW-1:0] b_ext;
    logic [AW-1:0] a_addr;
    logic [AW-1:0] b_addr;
    logic [AW-1:0] sz_raddr;

    logic          a_small;
    logic [AW-1:0] winner;
    logic [AW-1:0] loser;
    logic          par_we;
    logic [AW-1:0] par_waddr;
    logic [AW-1:0] par_wdata;
    logic [AW-1:0] sz_waddr;
    logic [SW-1:0] sz_wdata;

    logic [NW-1:0] nc;
    logic [NW-1:0] kc;
    logic [NW-1:0] k0;
    logic [NW-1:0] n_eff;
    logic [NW-1:0] k_eff;
    logic          cut_hit;
    logic          complete_now;
    logic          complete_after;
    logic          clr_last;

    logic [AW-1:0] root_pick;
    logic [XW-1:0] root_ext;

    assign a_ext  = {{AW{1'b0}}, item_reg.node_a};
    assign b_ext  = {{AW{1'b0}}, item_reg.node_b};
    assign a_addr = a_ext[AW-1:0];
    assign b_addr = b_ext[AW-1:0];

    assign nc    = NW'(node_count);
    assign kc    = NW'(cluster_count);
    assign n_eff = (nc > NW'(MAX_NODES)) ? NW'(MAX_NODES) : nc;
    assign k0    = (kc == '0) ? NW'(1) : kc;
    assign k_eff = (k0 > n_eff) ? n_eff : k0;

    assign cut_hit        = (CW'(count_reg) + CW'(k_eff)) >= CW'(n_eff);
    assign complete_now   = (n_eff != '0) && ((CW'(count_reg) + CW'(1)) >= CW'(n_eff));
    assign complete_after = (CW'(count_reg) + CW'(2)) >= CW'(n_eff);

    assign clr_last = (clr_reg == AW'(MAX_NODES - 1));
    assign clr_next = clr_last ? '0 : clr_reg + AW'(1);

    assign a_small = sa_reg < sz_rdata_reg;
    assign winner  = a_small ? rb_reg : ra_reg;
    assign loser   = a_small ? ra_reg : rb_reg;

    assign par_we    = ctrl.union_en | ctrl.clear_en;
    assign par_waddr = ctrl.clear_en ? clr_reg : loser;
    assign par_wdata = ctrl.clear_en ? clr_reg : winner;
    assign sz_waddr  = ctrl.clear_en ? clr_reg : winner;
    assign sz_wdata  = ctrl.clear_en ? SW'(1) : sa_reg + sz_rdata_reg;

    assign sz_raddr = (ctrl.size_sel == kuf_pkg::SZ_NODE) ? node_reg : ra_reg;

    always_comb
    begin
        case (ctrl.node_op)
            kuf_pkg::NODE_HOLD:   node_next = node_reg;
            kuf_pkg::NODE_SEED_A: node_next = a_addr;
            kuf_pkg::NODE_SEED_B: node_next = b_addr;
            kuf_pkg::NODE_WALK:   node_next = par_rdata_reg;
            default:              node_next = node_reg;
        endcase
    end

    assign root_pick = (ctrl.emit == kuf_pkg::OUT_UNION) ? winner : ra_reg;
    assign root_ext  = {{kuf_pkg::NODE_W{1'b0}}, root_pick};

    always_comb
    begin
        res_next   = '0;
        done_next  = 1'b0;
        count_next = count_reg;
        case (ctrl.emit)
            kuf_pkg::OUT_UNION:
            begin
                done_next                = 1'b1;
                res_next.accepted        = 1'b1;
                res_next.tree_edge_index = count_reg;
                res_next.cut_edge        = cut_hit;
                res_next.merged_root     = root_ext[kuf_pkg::NODE_W-1:0];
                res_next.tree_complete   = complete_after;
                count_next               = count_reg + kuf_pkg::NODE_W'(1);
            end
            kuf_pkg::OUT_SAME:
            begin
                done_next              = 1'b1;
                res_next.merged_root   = root_ext[kuf_pkg::NODE_W-1:0];
                res_next.tree_complete = complete_now;
            end
            kuf_pkg::OUT_BAD:
            begin
                done_next              = 1'b1;
                res_next.bad_node      = 1'b1;
                res_next.tree_complete = complete_now;
            end
            kuf_pkg::OUT_INIT:
            begin
                done_next  = 1'b1;
                count_next = '0;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            parent_mem[par_waddr] <= par_wdata;
        end
        par_rdata_reg <= parent_mem[node_next];
    end

    always_ff @(posedge clk)
    begin
        if (par_we)
        begin
            size_mem[sz_waddr] <= sz_wdata;
        end
        sz_rdata_reg <= size_mem[sz_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (start && ctrl.idle)
        begin
            item_reg <= item;
        end
        node_reg <= node_next;
        if (ctrl.latch_ra)
        begin
            ra_reg <= node_reg;
        end
        if (ctrl.latch_roots)
        begin
            rb_reg <= node_reg;
            sa_reg <= sz_rdata_reg;
        end
        result_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (ctrl.clear_en)
            begin
                clr_reg <= clr_next;
            end
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    assign stat.init      = !item_reg.action;
    assign stat.bad       = (NW'(item_reg.node_a) >= n_eff) || (NW'(item_reg.node_b) >= n_eff);
    assign stat.root_hit  = (par_rdata_reg == node_reg);
    assign stat.same_root = (node_reg == ra_reg);
    assign stat.clr_last  = clr_last;

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// File: design/kruskal_union_find_clustering_unit.sv
// Edge item: the unit walks endpoint a and then endpoint b up to their roots (each walk
// at most log2 of MAX_NODES deep), then joins the roots or reports a same-tree edge; a
// bad endpoint is reported with no walk. The next item is taken in the cycle done shows.
// Forest-reset item: a clearing pass over the parent and size memories. After rst_n the
// same pass runs with busy high; config registers take defaults.
// The receiver cannot stall: each result is on result for one cycle, marked by done.
`timescale 1ns / 1ps
`default_nettype none

module kruskal_union_find_clustering_unit #(
    parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire kuf_pkg::item_t                item,
    output logic                               done,
    output kuf_pkg::result_t                   result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [kuf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [kuf_pkg::CFG_W-1:0]     cfg_data
);

    logic [kuf_pkg::CFG_W-1:0] node_count_reg;
    logic [kuf_pkg::CFG_W-1:0] cluster_count_reg;
    kuf_pkg::uword_t ctrl;
    kuf_pkg::stat_t  stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg    <= kuf_pkg::NODE_COUNT_RST;
            cluster_count_reg <= kuf_pkg::CLUSTER_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                kuf_pkg::CFG_NODE_COUNT:    node_count_reg    <= cfg_data;
                kuf_pkg::CFG_CLUSTER_COUNT: cluster_count_reg <= cfg_data;
                default:                    node_count_reg    <= node_count_reg;
            endcase
        end
    end

    kuf_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    kuf_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .ctrl          (ctrl),
        .item          (item),
        .node_count    (node_count_reg),
        .cluster_count (cluster_count_reg),
        .stat          (stat),
        .done          (done),
        .result        (result)
    );

    assign busy = !ctrl.idle;

endmodule

`default_nettype wire

// File: design/kuf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module kuf_checker (
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire kuf_pkg::result_t result
);

    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy
    ) else $error("busy low right after an item was taken");

    a_done_after_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)
    ) else $error("result strobe without work in progress");

    a_bad_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && result.bad_node) |->
            (!result.accepted && !result.cut_edge && result.merged_root == '0)
    ) else $error("bad endpoint item carries edge data");

    a_reject_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done && !result.accepted) |->
            (!result.cut_edge && result.tree_edge_index == '0)
    ) else $error("rejected item carries a tree edge index or cut flag");

endmodule

bind kruskal_union_find_clustering_unit kuf_checker u_kuf_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

`default_nettype wire

// File: dv/kruskal_union_find_clustering_unit_tb.sv
`timescale 1ns / 1ps

module kruskal_union_find_clustering_unit_tb;
    import kuf_pkg::*;

    localparam int MAX_NODES    = MAX_NODES_DEF;
    localparam logic ACT_CLEAR  = 1'b0;
    localparam logic ACT_EDGE   = 1'b1;
    localparam int RANDOM_ITEMS = 1050;

    typedef enum bit {ROW_ITEM, ROW_REG} row_kind_e;
    typedef enum bit {CHECK_MODEL, CHECK_LIT} row_check_e;

    typedef struct packed {
        row_kind_e        kind;
        item_t            it;
        cfg_reg_e         reg_idx;
        logic [CFG_W-1:0] reg_val;
        row_check_e       check;
        result_t          want;
    } plan_row_t;

    localparam item_t NO_ITEM     = '0;
    localparam result_t NO_RESULT = '0;
    localparam int PLAN_LEN       = 29;

    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{ROW_ITEM, '{ACT_EDGE, 8'd0, 8'd1}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b1, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, '{ACT_EDGE, 8'd255, 8'd254}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b1, 8'd1, 1'b0, 8'd255, 1'b0, 1'b0}},
        '{ROW_ITEM, '{ACT_EDGE, 8'd1, 8'd0}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, '{ACT_EDGE, 8'd0, 8'd255}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b1, 8'd2, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, '{ACT_EDGE, 8'd5, 8'd5}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b0, 8'd0, 1'b0, 8'd5, 1'b0, 1'b0}},
        '{ROW_ITEM, '{ACT_EDGE, 8'd254, 8'd3}, CFG_NODE_COUNT, 9'd0, CHECK_MODEL, NO_RESULT},
        '{ROW_ITEM, '{ACT_EDGE, 8'd7, 8'd254}, CFG_NODE_COUNT, 9'd0, CHECK_MODEL, NO_RESULT},
        '{ROW_ITEM, '{ACT_CLEAR, 8'd255, 8'd255}, CFG_NODE_COUNT, 9'd0, CHECK_LIT, NO_RESULT},
        '{ROW_ITEM, '{ACT_EDGE, 8'd254, 8'd1}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b1, 8'd0, 1'b0, 8'd254, 1'b0, 1'b0}},
        '{ROW_REG, NO_ITEM, CFG_NODE_COUNT, 9'd4, CHECK_MODEL, NO_RESULT},
        '{ROW_REG, NO_ITEM, CFG_CLUSTER_COUNT, 9'd2, CHECK_MODEL, NO_RESULT},
        '{ROW_ITEM, '{ACT_CLEAR, 8'd0, 8'd0}, CFG_NODE_COUNT, 9'd0, CHECK_LIT, NO_RESULT},
        '{ROW_ITEM, '{ACT_EDGE, 8'd4, 8'd0}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b1}},
        '{ROW_ITEM, '{ACT_EDGE, 8'd0, 8'd1}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b1, 8'd0, 1'b0, 8'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, '{ACT_EDGE, 8'd2, 8'd3}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b1, 8'd1, 1'b0, 8'd2, 1'b0, 1'b0}},
        '{ROW_ITEM, '{ACT_EDGE, 8'd3, 8'd1}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b1, 8'd2, 1'b1, 8'd2, 1'b1, 1'b0}},
        '{ROW_ITEM, '{ACT_EDGE, 8'd0, 8'd3}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b0, 8'd0, 1'b0, 8'd2, 1'b1, 1'b0}},
        '{ROW_ITEM, '{ACT_EDGE, 8'd1, 8'd255}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1}},
        '{ROW_REG, NO_ITEM, CFG_NODE_COUNT, 9'd0, CHECK_MODEL, NO_RESULT},
        '{ROW_ITEM, '{ACT_EDGE, 8'd0, 8'd0}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b0, 1'b1}},
        '{ROW_REG, NO_ITEM, CFG_NODE_COUNT, 9'd511, CHECK_MODEL, NO_RESULT},
        '{ROW_REG, NO_ITEM, CFG_CLUSTER_COUNT, 9'd0, CHECK_MODEL, NO_RESULT},
        '{ROW_ITEM, '{ACT_CLEAR, 8'd170, 8'd85}, CFG_NODE_COUNT, 9'd0, CHECK_LIT, NO_RESULT},
        '{ROW_ITEM, '{ACT_EDGE, 8'd255, 8'd128}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b1, 8'd0, 1'b0, 8'd255, 1'b0, 1'b0}},
        '{ROW_REG, NO_ITEM, CFG_CLUSTER_COUNT, 9'd511, CHECK_MODEL, NO_RESULT},
        '{ROW_ITEM, '{ACT_EDGE, 8'd1, 8'd2}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b1, 8'd1, 1'b1, 8'd1, 1'b0, 1'b0}},
        '{ROW_REG, NO_ITEM, CFG_NODE_COUNT, 9'd1, CHECK_MODEL, NO_RESULT},
        '{ROW_ITEM, '{ACT_EDGE, 8'd0, 8'd0}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b1, 1'b0}},
        '{ROW_ITEM, '{ACT_EDGE, 8'd0, 8'd1}, CFG_NODE_COUNT, 9'd0,
          CHECK_LIT, '{1'b0, 8'd0, 1'b0, 8'd0, 1'b1, 1'b1}}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    item_t item = '0;
    logic done;
    result_t result;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    cfg_reg_e cfg_index = CFG_NODE_COUNT;
    logic [CFG_W-1:0] cfg_data = '0;

    int parent_mem [MAX_NODES];
    int size_mem [MAX_NODES];
    int tree_edges = 0;
    int cfg_nodes = 0;
    int cfg_clusters = 0;
    result_t due_results [$];

    int errors = 0;
    int items_sent = 0;
    int random_sent = 0;
    int results_seen = 0;
    int clears = 0;
    int joins = 0;
    int same_tree = 0;
    int bad_ends = 0;
    int reg_writes = 0;
    int burst_left = 1;
    bit gaps_on = 1'b1;

    kruskal_union_find_clustering_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic void clear_forest();
        for (int i = 0; i < MAX_NODES; i++)
        begin
            parent_mem[i] = i;
            size_mem[i] = 1;
        end
        tree_edges = 0;
    endfunction

    function automatic int root_of_node(int node);
        int steps;
        steps = 0;
        while (parent_mem[node] != node && steps < MAX_NODES)
        begin
            node = parent_mem[node];
            steps++;
        end
        return node;
    endfunction

    function automatic result_t predict_union(item_t it);
        result_t r;
        int n;
        int k;
        int ra;
        int rb;
        n = (cfg_nodes > MAX_NODES) ? MAX_NODES : cfg_nodes;
        k = (cfg_clusters == 0) ? 1 : cfg_clusters;
        if (k > n)
            k = n;
        r = '0;
        if (it.action == ACT_CLEAR)
        begin
            clear_forest();
            clears++;
            return r;
        end
        if (int'(it.node_a) >= n || int'(it.node_b) >= n)
        begin
            r.bad_node = 1'b1;
            bad_ends++;
        end
        else
        begin
            ra = root_of_node(int'(it.node_a));
            rb = root_of_node(int'(it.node_b));
            if (ra == rb)
            begin
                r.merged_root = ra[7:0];
                same_tree++;
            end
            else
            begin
                if (size_mem[ra] < size_mem[rb])
                begin
                    parent_mem[ra] = rb;
                    size_mem[rb] += size_mem[ra];
                    r.merged_root = rb[7:0];
                end
                else
                begin
                    parent_mem[rb] = ra;
                    size_mem[ra] += size_mem[rb];
                    r.merged_root = ra[7:0];
                end
                r.accepted = 1'b1;
                r.tree_edge_index = tree_edges[7:0];
                r.cut_edge = (tree_edges + k >= n);
                tree_edges++;
                joins++;
            end
        end
        r.tree_complete = (n > 0 && tree_edges >= n - 1);
        return r;
    endfunction

    function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected, expected nothing, got %p",
                         $time, result);
            end
            else
            begin
                want = due_results.pop_front();
                check_field("accepted", 9'(want.accepted), 9'(result.accepted));
                check_field("tree_edge_index", 9'(want.tree_edge_index),
                            9'(result.tree_edge_index));
                check_field("cut_edge", 9'(want.cut_edge), 9'(result.cut_edge));
                check_field("merged_root", 9'(want.merged_root), 9'(result.merged_root));
                check_field("tree_complete", 9'(want.tree_complete), 9'(result.tree_complete));
                check_field("bad_node", 9'(want.bad_node), 9'(result.bad_node));
            end
        end
    end

    task automatic send_item(item_t it, row_check_e check, result_t lit);
        result_t model;
        start <= 1'b1;
        item <= it;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        model = predict_union(it);
        due_results.push_back(check == CHECK_LIT ? lit : model);
        items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (due_results.size() != 0);
    endtask

    task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] val);
        drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_NODE_COUNT)
            cfg_nodes = int'(val);
        else
            cfg_clusters = int'(val);
        reg_writes++;
    endtask

    task automatic pace();
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
        if ($urandom_range(0, 99) < 2)
            drain();
    endtask

    task automatic feed(item_t it, bit noisy);
        if (noisy && $urandom_range(0, 99) < 8)
        begin
            it.action = ($urandom_range(0, 2) == 0) ? ACT_CLEAR : ACT_EDGE;
            it.node_a = 8'($urandom_range(0, 255));
            it.node_b = 8'($urandom_range(0, 255));
        end
        send_item(it, CHECK_MODEL, NO_RESULT);
        random_sent++;
        pace();
    endtask

    initial
    begin
        int phase;
        int pick;
        int nodes;
        int clusters;
        int n_eff;
        int span;
        int mult;
        int offs;
        int a;
        int b;
        int tmp;
        int edges;
        int directed;

        clear_forest();
        cfg_nodes = int'(NODE_COUNT_RST);
        cfg_clusters = int'(CLUSTER_COUNT_RST);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (PLAN[i])
        begin
            if (PLAN[i].kind == ROW_REG)
                write_reg(PLAN[i].reg_idx, PLAN[i].reg_val);
            else
            begin
                send_item(PLAN[i].it, PLAN[i].check, PLAN[i].want);
                pace();
            end
        end
        directed = items_sent;

        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (phase == 0 || pick < 6)
                nodes = MAX_NODES;
            else if (pick < 60)
                nodes = $urandom_range(2, 12);
            else if (pick < 82)
                nodes = $urandom_range(13, 40);
            else if (pick < 92)
                nodes = $urandom_range(41, 255);
            else if (pick < 96)
                nodes = $urandom_range(0, 1);
            else
                nodes = $urandom_range(257, 511);
            n_eff = (nodes > MAX_NODES) ? MAX_NODES : nodes;

            pick = $urandom_range(0, 99);
            if (pick < 65)
                clusters = $urandom_range(1, (n_eff > 1) ? n_eff : 1);
            else if (pick < 80)
                clusters = 0;
            else if (pick < 90)
                clusters = 1;
            else
                clusters = $urandom_range(n_eff, 511);

            write_reg(CFG_NODE_COUNT, nodes[CFG_W-1:0]);
            if (phase == 0 || $urandom_range(0, 3) != 0)
                write_reg(CFG_CLUSTER_COUNT, clusters[CFG_W-1:0]);
            gaps_on = ($urandom_range(0, 3) != 0);

            feed(item_t'{ACT_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))},
                 1'b0);

            // balanced merges over a permuted power-of-two subset build the deepest trees
            if (phase == 0 || $urandom_range(0, 2) == 0)
            begin
                span = 1;
                while (span * 2 <= n_eff)
                    span *= 2;
                mult = $urandom_range(0, 127) * 2 + 1;
                offs = $urandom_range(0, 255);
                for (int s = 1; s < span && random_sent < RANDOM_ITEMS; s *= 2)
                begin
                    for (int i = 0; i < span; i += 2 * s)
                    begin
                        a = (i * mult + offs) % span;
                        b = ((i + s) * mult + offs) % span;
                        if ($urandom_range(0, 1) == 1)
                        begin
                            tmp = a;
                            a = b;
                            b = tmp;
                        end
                        feed(item_t'{ACT_EDGE, a[7:0], b[7:0]}, 1'b0);
                    end
                end
            end

            edges = 3 * n_eff + 6;
            if (edges > 90)
                edges = 90;
            for (int e = 0; e < edges && random_sent < RANDOM_ITEMS; e++)
            begin
                if (n_eff == 0 || $urandom_range(0, 99) < 10)
                    a = $urandom_range(0, 255);
                else
                    a = $urandom_range(0, n_eff - 1);
                if (n_eff == 0 || $urandom_range(0, 99) < 10)
                    b = $urandom_range(0, 255);
                else
                    b = $urandom_range(0, n_eff - 1);
                feed(item_t'{ACT_EDGE, a[7:0], b[7:0]}, 1'b1);
            end
            phase++;
        end

        drain();
        repeat (40) @(posedge clk);
        $display("Ran %0d items (%0d from the directed table) over %0d random data sets, %0d results",
                 items_sent, directed, phase, results_seen);
        $display("Saw %0d joins, %0d same-tree edges, %0d bad endpoints, %0d forest clears, %0d register writes",
                 joins, same_tree, bad_ends, clears, reg_writes);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("%0t: timeout with %0d results outstanding", $time, due_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
design/kuf_pkg.sv
design/kuf_useq.sv
design/kuf_datapath.sv
design/kruskal_union_find_clustering_unit.sv
design/kuf_checker.sv
dv/kruskal_union_find_clustering_unit_tb.sv
